// ===== hw/rtl/gbr_pkg.sv =====
// Shared types and constants for the RGB Gaussian blur block.
package gbr_pkg;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int ROW_W        = 16;
    localparam int COL_W        = 11;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int ACC_W        = CH_W + 4;

    // APB register map: one 32-bit register per word
    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    // result kinds, in emit order, as bit positions of a job mask
    localparam int NUM_RES = 4;
    localparam int RES_UL  = 0;   // (r-1, c-1)
    localparam int RES_UE  = 1;   // (r-1, c), last column
    localparam int RES_LL  = 2;   // (r, c-1), last row
    localparam int RES_LE  = 3;   // (r, c), last row and last column

    // 1 2 1 / 2 4 2 / 1 2 1, in sixteenths
    localparam logic [2:0][2:0][2:0] GAUSS_W = {
        {3'd1, 3'd2, 3'd1},
        {3'd2, 3'd4, 3'd2},
        {3'd1, 3'd2, 3'd1}
    };

    typedef logic [PIX_W-1:0] pix_t;

    // [row][col]: row 0 oldest line, col 0 oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
    } gbr_cfg_t;

    typedef struct packed {
        win_t               win;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [NUM_RES-1:0] mask;
        logic               r_ge1;
        logic               r_ge2;
        logic               c_ge1;
        logic               c_ge2;
        logic               frame_end;
    } gbr_job_t;

endpackage

// ===== hw/rtl/gbr_if.sv =====
// Pixel input and blurred result channel interfaces.
interface gbr_pix_if;
    import gbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

interface gbr_res_if;
    import gbr_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             run_end;
    logic             frame_end;

    modport source (output valid, output out_row, output out_col, output out_red,
                    output out_green, output out_blue, output run_end,
                    output frame_end, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_red,
                    input out_green, input out_blue, input run_end,
                    input frame_end, output ready);
endinterface

// ===== hw/rtl/gbr_front.sv =====
// Front end: raster counters, line buffers, 3x3 window and job classification.
module gbr_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    gbr_pix_if.sink                   pix,
    input  gbr_pkg::gbr_cfg_t         cfg,
    input  logic [gbr_pkg::QLVL_W-1:0] q_level,
    output logic                      push,
    output gbr_pkg::gbr_job_t         push_job
);
    import gbr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             col_wrap;
    logic [ROW_W:0]   row_pre;
    logic [CW-1:0]    cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [WW-1:0]    col_inc;
    logic [ROW_W:0]   row_inc;
    logic             last_col, last_row;
    logic [NUM_RES-1:0] mask;
    logic             in_fire;

    // stage 1: one item whose line read is in flight
    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [NUM_RES-1:0] s1_mask_reg;
    logic               s1_r_ge1_reg, s1_r_ge2_reg, s1_c_ge1_reg, s1_c_ge2_reg;
    logic               s1_fend_reg;

    // line buffer entry: {row r-2, row r-1}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd_reg;
    logic [2*PIX_W-1:0] line_cur;
    logic [2*PIX_W-1:0] line_wr;
    logic               fwd_valid_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;

    win_t win_reg, win_next;

    always_comb
    begin
        if (cfg.width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.width);
        h_eff = (cfg.height == '0) ? ROW_W'(1) : cfg.height;
    end

    // position of the pixel being accepted and of the next one
    always_comb
    begin
        col_wrap = WW'(col_cnt_reg) >= w_eff;
        row_pre  = col_wrap ? ((ROW_W+1)'(row_cnt_reg) + (ROW_W+1)'(1))
                            : (ROW_W+1)'(row_cnt_reg);
        cur_col  = col_wrap ? '0 : col_cnt_reg;
        cur_row  = (row_pre >= (ROW_W+1)'(h_eff)) ? '0 : row_pre[ROW_W-1:0];
        col_inc  = WW'(cur_col) + WW'(1);
        row_inc  = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1);
        last_col = col_inc == w_eff;
        last_row = row_inc == (ROW_W+1)'(h_eff);

        if (col_inc >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_inc >= (ROW_W+1)'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_cnt_next = col_inc[CW-1:0];
            row_cnt_next = cur_row;
        end

        mask[RES_UL] = (cur_row != '0) && (cur_col != '0);
        mask[RES_UE] = (cur_row != '0) && last_col;
        mask[RES_LL] = last_row && (cur_col != '0);
        mask[RES_LE] = last_row && last_col;
    end

    // one slot kept for the item in stage 1
    assign pix.ready = ({1'b0, q_level} + {{QLVL_W{1'b0}}, s1_valid_reg})
                       < (QLVL_W+1)'(QUEUE_DEPTH);
    assign in_fire   = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= in_fire && s1_valid_reg && (s1_col_reg == cur_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= {pix.in_red, pix.in_green, pix.in_blue};
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_mask_reg  <= mask;
            s1_r_ge1_reg <= cur_row != '0;
            s1_r_ge2_reg <= |cur_row[ROW_W-1:1];
            s1_c_ge1_reg <= cur_col != '0;
            s1_c_ge2_reg <= cur_col > CW'(1);
            s1_fend_reg  <= last_row && last_col;
        end
        fwd_data_reg <= line_wr;
    end

    // back-to-back accesses to the same column (one-pixel-wide image)
    assign line_cur = fwd_valid_reg ? fwd_data_reg : line_rd_reg;
    assign line_wr  = {line_cur[PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= line_wr;
        if (in_fire)
            line_rd_reg <= line_mem[cur_col];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = line_cur[2*PIX_W-1:PIX_W];
        win_next[1][2] = line_cur[PIX_W-1:0];
        win_next[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg)
            win_reg <= win_next;
    end

    always_comb
    begin
        push               = s1_valid_reg && (s1_mask_reg != '0);
        push_job.win       = win_next;
        push_job.row       = s1_row_reg;
        push_job.col       = COL_W'(s1_col_reg);
        push_job.mask      = s1_mask_reg;
        push_job.r_ge1     = s1_r_ge1_reg;
        push_job.r_ge2     = s1_r_ge2_reg;
        push_job.c_ge1     = s1_c_ge1_reg;
        push_job.c_ge2     = s1_c_ge2_reg;
        push_job.frame_end = s1_fend_reg;
    end

endmodule

// ===== hw/rtl/gbr_job_fifo.sv =====
// Short job queue between the front end and the blur back end.
module gbr_job_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  gbr_pkg::gbr_job_t          push_job,
    input  logic                       pop,
    output logic                       head_valid,
    output gbr_pkg::gbr_job_t          head_job,
    output logic [gbr_pkg::QLVL_W-1:0] level
);
    import gbr_pkg::*;

    gbr_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic              do_push, do_pop;

    assign do_push    = push && (level_reg != QLVL_W'(QUEUE_DEPTH));
    assign do_pop     = pop && (level_reg != '0);
    assign head_valid = level_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                level_reg <= level_reg + QLVL_W'(1);
            else if (do_pop && !do_push)
                level_reg <= level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/gbr_back.sv =====
// Back end: walks each job's results, blurs one per cycle unless the output stalls, output register.
module gbr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  gbr_pkg::gbr_job_t head_job,
    output logic              pop,
    gbr_res_if.source         res
);
    import gbr_pkg::*;

    logic [NUM_RES-1:0] done_reg, done_next;
    logic [NUM_RES-1:0] remain, sel, rest;
    logic               last, step;

    logic               cr_hi, cc_hi;
    logic               up_ok, left_ok;
    logic               row_ok, col_ok;
    logic [1:0]         tap_row, tap_col;
    pix_t               centre, tap_px;
    logic [ACC_W-1:0]   acc_r, acc_g, acc_b;
    logic [ROW_W-1:0]   prow;
    logic [COL_W-1:0]   pcol;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [CH_W-1:0]    out_red_reg, out_green_reg, out_blue_reg;
    logic               run_end_reg, frame_end_reg;

    // lowest pending result of the head job
    always_comb
    begin
        remain = head_job.mask & ~done_reg;
        sel    = remain & (~remain + NUM_RES'(1));
        rest   = remain & ~sel;
        last   = rest == '0;
        step   = head_valid && (!out_valid_reg || res.ready);
        pop    = step && last;
        if (pop)
            done_next = '0;
        else if (step)
            done_next = done_reg | sel;
        else
            done_next = done_reg;
    end

    // neighbours outside the image take the centre pixel
    always_comb
    begin
        cr_hi   = sel[RES_LL] | sel[RES_LE];
        cc_hi   = sel[RES_UE] | sel[RES_LE];
        up_ok   = cr_hi ? head_job.r_ge1 : head_job.r_ge2;
        left_ok = cc_hi ? head_job.c_ge1 : head_job.c_ge2;
        centre  = head_job.win[cr_hi ? 2'd2 : 2'd1][cc_hi ? 2'd2 : 2'd1];
        prow    = cr_hi ? head_job.row : head_job.row - ROW_W'(1);
        pcol    = cc_hi ? head_job.col : head_job.col - COL_W'(1);
        acc_r   = '0;
        acc_g   = '0;
        acc_b   = '0;
        row_ok  = 1'b0;
        col_ok  = 1'b0;
        tap_row = '0;
        tap_col = '0;
        tap_px  = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                row_ok  = (i == 0) ? up_ok : ((i == 2) ? !cr_hi : 1'b1);
                col_ok  = (j == 0) ? left_ok : ((j == 2) ? !cc_hi : 1'b1);
                tap_row = cr_hi ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
                tap_col = cc_hi ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
                tap_px  = (row_ok && col_ok) ? head_job.win[tap_row][tap_col] : centre;
                acc_r   = acc_r + ACC_W'(GAUSS_W[i][j]) * ACC_W'(tap_px[3*CH_W-1:2*CH_W]);
                acc_g   = acc_g + ACC_W'(GAUSS_W[i][j]) * ACC_W'(tap_px[2*CH_W-1:CH_W]);
                acc_b   = acc_b + ACC_W'(GAUSS_W[i][j]) * ACC_W'(tap_px[CH_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (step)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_row_reg   <= prow;
            out_col_reg   <= pcol;
            out_red_reg   <= acc_r[ACC_W-1:4];
            out_green_reg <= acc_g[ACC_W-1:4];
            out_blue_reg  <= acc_b[ACC_W-1:4];
            run_end_reg   <= last;
            frame_end_reg <= sel[RES_LE] && head_job.frame_end;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_row   = out_row_reg;
    assign res.out_col   = out_col_reg;
    assign res.out_red   = out_red_reg;
    assign res.out_green = out_green_reg;
    assign res.out_blue  = out_blue_reg;
    assign res.run_end   = run_end_reg;
    assign res.frame_end = frame_end_reg;

endmodule

// ===== hw/rtl/gaussian_blur_3x3_rgb_top.sv =====
// Top level of the streaming 3x3 Gaussian blur for RGB pixels.
//
// Channel   Dir  Carries                               Transfer when
// -------   ---  ------------------------------------  -------------------------
// pix       in   in_red/in_green/in_blue, raster order  pix.valid && pix.ready
// res       out  row, col, RGB blur, run_end, frame_end res.valid && res.ready
// APB       in   width_px @0x0, height_px @0x4          psel && penable && pwrite
//
// Cycles: one pixel per clock inside a row while the job queue has room.
// Each pixel yields at most one result there; pixels in the last column
// or last row yield up to four, and the back end emits one result per
// clock unless the result output stalls. A four-entry job queue lets the
// front keep taking pixels while the back end works through them.
// Path: a completing pixel passes the stage-1 registers, a job queue slot
// and the output register before its results leave the block.
// Reset: counters, window and queue clear at once; the line buffers are
// not cleared (entries are only read after being written for the pixels
// that count). Either side may stall any time without loss.
module gaussian_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    gbr_pix_if.sink                          pix,
    gbr_res_if.source                        res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbr_pkg::PADDR_W-1:0]      paddr,
    input  logic [gbr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gbr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import gbr_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    cfg_write;
    gbr_cfg_t                cfg;

    logic                    push, pop, head_valid;
    gbr_job_t                push_job, head_job;
    logic [QLVL_W-1:0]       q_level;

    // APB: no wait states, word addressed registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    // front: counters, line buffers, window; one job per pixel with results
    gbr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .cfg      (cfg),
        .q_level  (q_level),
        .push     (push),
        .push_job (push_job)
    );

    gbr_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .level      (q_level)
    );

    // back: one blurred result per clock unless the output stalls, registered output
    gbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .res        (res)
    );

endmodule

// ===== bench/gbr_blur_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RGB blur: follows register writes, predicts blurred pixels, compares results.
module gbr_blur_checker #(
    parameter int MAX_COLS = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gbr_pix_if                             pix,
    gbr_res_if                             res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [gbr_pkg::PADDR_W-1:0]    paddr,
    input  logic [gbr_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fail_total,
    output int                             backlog
);
    import gbr_pkg::*;

    localparam int SHOW_MAX = 30;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             run_end;
        logic             frame_end;
    } blur_px_t;

    // predictor state
    pix_t                    older_line [MAX_COLS];
    pix_t                    newer_line [MAX_COLS];
    pix_t                    win [3][3];
    int                      row_pos;
    int                      col_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    blur_px_t pending_blurs [$];
    int       errors;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= SHOW_MAX)
            $display("%0t blur check: %s", $time, msg);
    endtask

    // Blur of image pixel (prow,pcol) whose centre sits at win[cr][cc].
    // Neighbours off the image take the centre value.
    function automatic blur_px_t blur_at(input int prow, input int pcol, input int cr,
                                         input int cc, input int w, input int h);
        blur_px_t o;
        pix_t     centre;
        pix_t     px;
        int       acc_r;
        int       acc_g;
        int       acc_b;
        int       wt;
        int       dr;
        int       dc;
        centre = win[cr][cc];
        acc_r  = 0;
        acc_g  = 0;
        acc_b  = 0;
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                px = centre;
                if (prow + dr >= 0 && prow + dr < h && pcol + dc >= 0 && pcol + dc < w &&
                    cr + dr >= 0 && cr + dr <= 2 && cc + dc >= 0 && cc + dc <= 2)
                    px = win[cr + dr][cc + dc];
                wt = (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1);
                acc_r += wt * int'(px[23:16]);
                acc_g += wt * int'(px[15:8]);
                acc_b += wt * int'(px[7:0]);
            end
        end
        o.row       = ROW_W'(prow);
        o.col       = COL_W'(pcol);
        o.red       = CH_W'(acc_r >> 4);
        o.green     = CH_W'(acc_g >> 4);
        o.blue      = CH_W'(acc_b >> 4);
        o.run_end   = 1'b0;
        o.frame_end = (prow == h - 1) && (pcol == w - 1);
        return o;
    endfunction

    // One pixel in: shift window, update line stores, queue the blurs it completes.
    task automatic predict_blurs(input pix_t p);
        blur_px_t found [4];
        int       n;
        int       w;
        int       h;
        int       r;
        int       c;
        int       i;
        w = (width_reg == 0) ? 1 : ((int'(width_reg) > MAX_COLS) ? MAX_COLS : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        // a shrunk geometry takes hold on the next pixel
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]     = older_line[c];
        win[1][2]     = newer_line[c];
        win[2][2]     = p;
        older_line[c] = newer_line[c];
        newer_line[c] = p;

        n = 0;
        if (r >= 1 && c >= 1)
        begin
            found[n] = blur_at(r - 1, c - 1, 1, 1, w, h);
            n++;
        end
        if (r >= 1 && c == w - 1)
        begin
            found[n] = blur_at(r - 1, c, 1, 2, w, h);
            n++;
        end
        if (r == h - 1 && c >= 1)
        begin
            found[n] = blur_at(r, c - 1, 2, 1, w, h);
            n++;
        end
        if (r == h - 1 && c == w - 1)
        begin
            found[n] = blur_at(r, c, 2, 2, w, h);
            n++;
        end
        for (i = 0; i < n; i++)
        begin
            found[i].run_end = (i == n - 1);
            pending_blurs.push_back(found[i]);
        end

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic field_check(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v, input blur_px_t want);
        if (got_v !== want_v)
            report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0h, expected %0h",
                                      want.row, want.col, name, got_v, want_v));
    endtask

    task automatic check_blur(input blur_px_t got);
        blur_px_t want;
        if (pending_blurs.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected: row %0d col %0d",
                                      got.row, got.col));
        end
        else
        begin
            want = pending_blurs.pop_front();
            field_check("out_row",   got.row,       want.row,       want);
            field_check("out_col",   got.col,       want.col,       want);
            field_check("out_red",   got.red,       want.red,       want);
            field_check("out_green", got.green,     want.green,     want);
            field_check("out_blue",  got.blue,      want.blue,      want);
            field_check("run_end",   got.run_end,   want.run_end,   want);
            field_check("frame_end", got.frame_end, want.frame_end, want);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        blur_px_t got;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < MAX_COLS; i++)
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (i = 0; i < 9; i++)
                win[i / 3][i % 3] = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            pending_blurs.delete();
            errors     = 0;
            fail_total <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_WIDTH)
                    width_reg = pwdata[WIDTH_REG_W-1:0];
                else if (paddr[PADDR_W-1:2] == REG_HEIGHT)
                    height_reg = pwdata[HEIGHT_REG_W-1:0];
            end
            if (pix.valid && pix.ready)
                predict_blurs({pix.in_red, pix.in_green, pix.in_blue});
            if (res.valid && res.ready)
            begin
                got.row       = res.out_row;
                got.col       = res.out_col;
                got.red       = res.out_red;
                got.green     = res.out_green;
                got.blue      = res.out_blue;
                got.run_end   = res.run_end;
                got.frame_end = res.frame_end;
                check_blur(got);
            end
            fail_total <= errors;
            backlog    <= pending_blurs.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the RGB blur testbench: clock, reset, pixel and register stimulus, verdict.
module tb_top;
    import gbr_pkg::*;

    localparam int MAX_COLS      = 2048;
    localparam int CYCLE_LIMIT   = 200000; // watchdog bound on the whole run
    localparam int DIRECTED_PX   = 23;
    localparam int RANDOM_PX     = 370;
    localparam int SETTLE_CYCLES = 10;     // output register path plus the job queue, with margin
    localparam int IDLE_PCT      = 9;
    localparam int PRIME_W       = 12;     // widest geometry used by the random part
    localparam int PRIME_H       = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_total;
    int   backlog;
    int   cycles;
    int   pixels_sent;
    logic steady;          // high while neither side idles

    // geometry last written, used only to size the frames we stream
    logic [WIDTH_REG_W-1:0]  width_set;
    logic [HEIGHT_REG_W-1:0] height_set;

    gbr_pix_if pix ();
    gbr_res_if res ();

    gaussian_blur_3x3_rgb_top #(
        .MAX_WIDTH (MAX_COLS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gbr_blur_checker #(
        .MAX_COLS (MAX_COLS)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_total (fail_total),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or results that never arrive end here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result sink: stalls about 9 percent of the time, never during the steady stretch.
    always @(posedge clk)
    begin
        res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Register write: setup cycle, then access cycle; the write lands at the
    // edge where penable is high (pready is tied high but honored anyway).
    // Ends only after psel has been low at a clock edge, so the next call never
    // re-drives psel within the same time step.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Both registers, always while the block is idle.
    task automatic set_geometry(input logic [WIDTH_REG_W-1:0] w,
                                input logic [HEIGHT_REG_W-1:0] h);
        width_set  = w;
        height_set = h;
        apb_write(REG_WIDTH, APB_DATA_W'(w));
        apb_write(REG_HEIGHT, APB_DATA_W'(h));
    endtask

    // Pixel count of one frame as the block sees it (0 -> 1, width clamps).
    function automatic int frame_pixels();
        int w;
        int h;
        w = (width_set == 0) ? 1 : ((int'(width_set) > MAX_COLS) ? MAX_COLS : int'(width_set));
        h = (height_set == 0) ? 1 : int'(height_set);
        return w * h;
    endfunction

    // Random pixel; each channel hits 0x00 or 0xFF now and then.
    function automatic pix_t random_pixel();
        pix_t p;
        int   i;
        p = pix_t'($urandom());
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 7) == 0)
                p[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // One pixel transfer. Starts right after an edge with valid untouched in
    // this step, returns right after the edge that completed the transfer.
    task automatic send_pixel(input pix_t p);
        steady = (pixels_sent >= 200) && (pixels_sent < 330);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.in_red   <= p[23:16];
        pix.in_green <= p[15:8];
        pix.in_blue  <= p[7:0];
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Drop valid, wait for the next edge so the scoreboard count includes
    // the last transfer, drain all expected results, then cover pixels that
    // produce no result but may still be in flight.
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int w;
        int h;
        int per_frame;
        int count;

        // block inputs known from time zero; result ready follows at the first edge
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        pix.valid    <= 1'b0;
        pix.in_red   <= '0;
        pix.in_green <= '0;
        pix.in_blue  <= '0;
        pixels_sent  = 0;
        steady       = 1'b0;
        width_set    = WIDTH_RESET;
        height_set   = HEIGHT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // zero width and height act as a 1x1 image: every pixel is its own
        // frame and blurs to itself
        set_geometry('0, '0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h5AA55A);
        settle();

        // smallest image with both sides above one; red saturated everywhere checks
        // the top of the sum, blue walks the low and high bits
        set_geometry(WIDTH_REG_W'(2), HEIGHT_REG_W'(2));
        send_pixel(24'hFF0001);
        send_pixel(24'hFF00FE);
        send_pixel(24'hFF007F);
        send_pixel(24'hFF0080);
        settle();

        // width register at its maximum (clamps to the line length) and the
        // tallest height; row 0 gives no results, then a mid-frame shrink to
        // 3x2 moves the position to the start of row 1 and closes the frame
        set_geometry('1, '1);
        send_random(5);
        settle();
        set_geometry(WIDTH_REG_W'(3), HEIGHT_REG_W'(2));
        send_random(3);
        settle();

        // one column: every horizontal neighbour falls back to the centre
        set_geometry(WIDTH_REG_W'(1), HEIGHT_REG_W'(3));
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        send_pixel(24'h123456);
        settle();

        // one row: all results interleave with the input, last one doubles up
        set_geometry(WIDTH_REG_W'(5), HEIGHT_REG_W'(1));
        send_random(5);
        settle();

        // ---- random ----
        // A full frame at the widest random geometry first: afterwards both
        // line stores hold real pixels in every column the random part can
        // touch, so mid-frame geometry changes never expose an unwritten entry.
        set_geometry(WIDTH_REG_W'(PRIME_W), HEIGHT_REG_W'(PRIME_H));
        send_random(PRIME_W * PRIME_H);
        settle();

        while (pixels_sent < DIRECTED_PX + RANDOM_PX)
        begin
            w = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, PRIME_W);
            h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
            set_geometry(WIDTH_REG_W'(w), HEIGHT_REG_W'(h));
            per_frame = frame_pixels();
            count     = per_frame * $urandom_range(1, 3);
            // now and then stop inside a frame so the next geometry change
            // lands mid-frame
            if ($urandom_range(0, 4) == 0)
                count = count - per_frame + $urandom_range(1, per_frame);
            send_random(count);
            settle();
        end

        if (fail_total == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gbr_pkg.sv
hw/rtl/gbr_if.sv
hw/rtl/gbr_front.sv
hw/rtl/gbr_job_fifo.sv
hw/rtl/gbr_back.sv
hw/rtl/gaussian_blur_3x3_rgb_top.sv
bench/gbr_blur_checker.sv
bench/tb_top.sv
